// File: rtl/sceq_pkg.sv
// Shared types and constants for the scan code event queue.
// No dependencies; imported by scan_code_event_queue and sceq_assert.
`default_nettype none

package sceq_pkg;

    localparam int FUNC_W = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 88;

    localparam logic [FUNC_W-1:0] FUNC_SCAN  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_KEY_TYPE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_DOWN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_UP   = 2'd2;

    localparam logic [7:0] PREFIX_BYTE = 8'he0;

    typedef struct packed {
        logic        [7:0]  ev_type;
        logic        [7:0]  ev_sub_type;
        logic signed [15:0] ev_x;
        logic signed [15:0] ev_y;
        logic        [15:0] ev_data_a;
        logic        [15:0] ev_data_b;
    } event_t;

    localparam int EVENT_W = $bits(event_t);

    typedef struct packed {
        logic        [15:0] in_data_b;
        logic        [15:0] in_data_a;
        logic signed [15:0] in_y;
        logic signed [15:0] in_x;
        logic        [7:0]  in_sub_type;
        logic        [7:0]  in_type;
        logic        [7:0]  scan_code;
    } in_beat_t;

    typedef struct packed {
        logic        [6:0]  pad;
        logic               scan_dropped;
        logic        [15:0] out_data_b;
        logic        [15:0] out_data_a;
        logic signed [15:0] out_y;
        logic signed [15:0] out_x;
        logic        [7:0]  out_sub_type;
        logic        [7:0]  out_type;
    } out_beat_t;

endpackage

`default_nettype wire

// File: rtl/sceq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sceq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/scan_code_event_queue.sv
// Scan code event queue: scan byte ring drained into an overwriting event ring.
// Depends on sceq_pkg and sceq_ram.
//
// One beat in, one beat out. A scan byte, a generic event or an unused func
// is taken and its result beat appears on the next cycle. A check first
// drains the scan ring: the scan RAM is read one byte per cycle, each byte
// but the E0 prefix written to the event RAM as it comes back; then, unless
// the event ring is empty, one event RAM read pops the oldest event, and the
// result beat is given. A new beat is taken only while the block is idle and
// its output register is free or being emptied.
`default_nettype none

module scan_code_event_queue
    import sceq_pkg::*;
#(
    parameter int SCAN_DEPTH  = 256,
    parameter int EVENT_DEPTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // scan_code, in_type, in_sub_type, in_x, in_y, in_data_a, in_data_b
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // func
    input  wire logic [FUNC_W-1:0]     s_tuser,
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // out_type, out_sub_type, out_x, out_y, out_data_a, out_data_b,
    // scan_dropped, zero pad
    output      logic [M_DATA_W-1:0]   m_tdata,
    // has_event
    output      logic                  m_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SPW = $clog2(SCAN_DEPTH);
    localparam int EPW = $clog2(EVENT_DEPTH);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DRAIN    = 3'd1;
    localparam logic [2:0] ST_POP      = 3'd2;
    localparam logic [2:0] ST_POP_DATA = 3'd3;

    function automatic logic [SPW-1:0] scan_wrap(input logic [SPW-1:0] p);
        return (p == SPW'(SCAN_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [EPW-1:0] ev_wrap(input logic [EPW-1:0] p);
        return (p == EPW'(EVENT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [2:0]     state_reg, state_next;
    logic [SPW-1:0] scan_rd_reg, scan_rd_next;
    logic [SPW-1:0] scan_wr_reg, scan_wr_next;
    logic [EPW-1:0] ev_rd_reg, ev_rd_next;
    logic [EPW-1:0] ev_wr_reg, ev_wr_next;
    logic           rd_pend_reg, rd_pend_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic           has_event_reg;
    out_beat_t      out_reg;
    logic [7:0]     key_type_reg, key_press_reg, key_up_reg;

    in_beat_t       in_beat;
    out_beat_t      out_next;
    logic           has_next;
    logic           out_load;
    logic           accept;

    logic           scan_we, scan_re;
    logic [7:0]     scan_rdata;
    logic           ev_we, ev_re;
    event_t         push_data;
    event_t         ev_rdata;
    logic           push_en;

    assign in_beat  = in_beat_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = has_event_reg;

    sceq_ram #(
        .WIDTH(8),
        .DEPTH(SCAN_DEPTH)
    ) u_scan_ram (
        .clk  (clk),
        .we   (scan_we),
        .waddr(scan_wr_reg),
        .wdata(in_beat.scan_code),
        .re   (scan_re),
        .raddr(scan_rd_reg),
        .rdata(scan_rdata)
    );

    sceq_ram #(
        .WIDTH(EVENT_W),
        .DEPTH(EVENT_DEPTH)
    ) u_event_ram (
        .clk  (clk),
        .we   (ev_we),
        .waddr(ev_wr_reg),
        .wdata(push_data),
        .re   (ev_re),
        .raddr(ev_rd_reg),
        .rdata(ev_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        scan_rd_next  = scan_rd_reg;
        scan_wr_next  = scan_wr_reg;
        ev_rd_next    = ev_rd_reg;
        ev_wr_next    = ev_wr_reg;
        rd_pend_next  = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        scan_we       = 1'b0;
        scan_re       = 1'b0;
        ev_we         = 1'b0;
        ev_re         = 1'b0;
        push_en       = 1'b0;
        push_data     = '0;
        out_load      = 1'b0;
        out_next      = '0;
        has_next      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        FUNC_SCAN:
                        begin
                            out_load = 1'b1;
                            if (scan_wrap(scan_wr_reg) == scan_rd_reg)
                            begin
                                out_next.scan_dropped = 1'b1;
                            end
                            else
                            begin
                                scan_we      = 1'b1;
                                scan_wr_next = scan_wrap(scan_wr_reg);
                            end
                        end
                        FUNC_EVENT:
                        begin
                            out_load              = 1'b1;
                            push_en               = 1'b1;
                            push_data.ev_type     = in_beat.in_type;
                            push_data.ev_sub_type = in_beat.in_sub_type;
                            push_data.ev_x        = in_beat.in_x;
                            push_data.ev_y        = in_beat.in_y;
                            push_data.ev_data_a   = in_beat.in_data_a;
                            push_data.ev_data_b   = in_beat.in_data_b;
                        end
                        FUNC_CHECK:
                        begin
                            state_next = ST_DRAIN;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                // byte read last cycle is pushed, unless it is the E0 prefix, while the next one is read
                if (rd_pend_reg && (scan_rdata != PREFIX_BYTE))
                begin
                    push_en               = 1'b1;
                    push_data.ev_type     = key_type_reg;
                    push_data.ev_sub_type = scan_rdata[7] ? key_up_reg : key_press_reg;
                    push_data.ev_data_a   = {9'd0, scan_rdata[6:0]};
                end
                if (scan_rd_reg != scan_wr_reg)
                begin
                    scan_re      = 1'b1;
                    scan_rd_next = scan_wrap(scan_rd_reg);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (ev_rd_reg != ev_wr_reg)
                begin
                    ev_re      = 1'b1;
                    ev_rd_next = ev_wrap(ev_rd_reg);
                    state_next = ST_POP_DATA;
                end
                else
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_POP_DATA:
            begin
                out_load              = 1'b1;
                has_next              = 1'b1;
                out_next.out_type     = ev_rdata.ev_type;
                out_next.out_sub_type = ev_rdata.ev_sub_type;
                out_next.out_x        = ev_rdata.ev_x;
                out_next.out_y        = ev_rdata.ev_y;
                out_next.out_data_a   = ev_rdata.ev_data_a;
                out_next.out_data_b   = ev_rdata.ev_data_b;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // full event ring drops its oldest entry
        if (push_en)
        begin
            ev_we      = 1'b1;
            ev_wr_next = ev_wrap(ev_wr_reg);
            if (ev_wrap(ev_wr_reg) == ev_rd_reg)
            begin
                ev_rd_next = ev_wrap(ev_rd_reg);
            end
        end

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_rd_reg   <= '0;
            scan_wr_reg   <= '0;
            ev_rd_reg     <= '0;
            ev_wr_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            has_event_reg <= 1'b0;
            key_type_reg  <= 8'd0;
            key_press_reg <= 8'd0;
            key_up_reg    <= 8'd1;
        end
        else
        begin
            state_reg    <= state_next;
            scan_rd_reg  <= scan_rd_next;
            scan_wr_reg  <= scan_wr_next;
            ev_rd_reg    <= ev_rd_next;
            ev_wr_reg    <= ev_wr_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (out_load)
            begin
                has_event_reg <= has_next;
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_KEY_TYPE: key_type_reg  <= cfg_wdata;
                    REG_KEY_DOWN: key_press_reg <= cfg_wdata;
                    REG_KEY_UP:   key_up_reg    <= cfg_wdata;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sceq_checker.sv
// Port-level assertions for the scan code event queue, bound to the top level.
// Depends on sceq_pkg and scan_code_event_queue.
`default_nettype none

module sceq_assert
    import sceq_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [FUNC_W-1:0]     s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_DATA_W-1:0]   m_tdata,
    input wire logic                  m_tuser
);

    out_beat_t out_beat;

    assign out_beat = out_beat_t'(m_tdata);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !m_tvalid || m_tready)
        else $error("input beat taken while result beat is stuck");

    a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == FUNC_SCAN |=> m_tvalid && !m_tuser)
        else $error("scan byte did not give a plain result next cycle");

    a_check_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == FUNC_CHECK |=> !m_tvalid && !s_tready)
        else $error("check finished too early");

    a_pop_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !out_beat.scan_dropped && out_beat.pad == '0)
        else $error("popped event flagged as dropped byte");

endmodule

bind scan_code_event_queue sceq_assert u_sceq_assert (.*);

`default_nettype wire
